>>> hdl/bitmap_find_first_zero_macros.svh
// Assertion macros for the bitmap find-first-zero block.
// Used by the port checker; needs nothing else.
`ifndef BITMAP_FIND_FIRST_ZERO_MACROS_SVH
`define BITMAP_FIND_FIRST_ZERO_MACROS_SVH

// Property checked at each rising clock edge, ignored while reset is held.
`define BFZ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");

// Property checked at each rising clock edge, reset included.
`define BFZ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

>>> hdl/bfz_pkg.sv
// Shared types, constants and helpers for the bitmap find-first-zero block.
// No dependencies.
`timescale 1ns / 1ps

package bfz_pkg;

    // Map geometry
    localparam int WORDS_DEF  = 32;
    localparam int WORD_W     = 32;
    localparam int BIT_IX_W   = 5;
    localparam int POS_W      = 10;
    localparam int ACT_W      = 3;
    localparam int SCAN_LIMIT = 32;   // words that hold indexes below 1024

    typedef enum logic [ACT_W-1:0] {
        ACT_GET   = 3'd0,
        ACT_SET   = 3'd1,
        ACT_CLEAR = 3'd2,
        ACT_FIND  = 3'd3,
        ACT_FILL0 = 3'd4,
        ACT_FILL1 = 3'd5
    } action_e;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_FILL
    } state_e;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] bit_position;
    } in_beat_t;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [POS_W-1:0] free_index;
    } out_beat_t;

    // Address width for a memory of the given depth (at least one bit)
    function automatic int addr_width(input int depth);
        addr_width = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> hdl/bfz_mem.sv
// Bitmap word store: one write port, one read port with registered data.
// Depends on bfz_pkg.
`timescale 1ns / 1ps

module bfz_mem #(
    parameter int WORDS = bfz_pkg::WORDS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [bfz_pkg::addr_width(WORDS)-1:0]    wr_addr,
    input  logic [bfz_pkg::WORD_W-1:0]               wr_data,
    input  logic                                     rd_en,
    input  logic [bfz_pkg::addr_width(WORDS)-1:0]    rd_addr,
    output logic [bfz_pkg::WORD_W-1:0]               rd_data
);

    logic [bfz_pkg::WORD_W-1:0] mem_reg [WORDS];
    logic [bfz_pkg::WORD_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/bfz_ctrl.sv
// Sequencer for the bitmap block: clearing pass, read-modify-write,
// first-zero scan and whole-map fill. Depends on bfz_pkg.
`timescale 1ns / 1ps

module bfz_ctrl #(
    parameter int WORDS = bfz_pkg::WORDS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input beats
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  bfz_pkg::in_beat_t                        s_data,
    // results toward the output register
    output logic                                     res_valid,
    input  logic                                     res_ready,
    output bfz_pkg::out_beat_t                       res_data,
    // memory ports
    output logic                                     wr_en,
    output logic [bfz_pkg::addr_width(WORDS)-1:0]    wr_addr,
    output logic [bfz_pkg::WORD_W-1:0]               wr_data,
    output logic                                     rd_en,
    output logic [bfz_pkg::addr_width(WORDS)-1:0]    rd_addr,
    input  logic [bfz_pkg::WORD_W-1:0]               rd_data
);

    localparam int AW         = bfz_pkg::addr_width(WORDS);
    localparam int SCAN_WORDS = (WORDS < bfz_pkg::SCAN_LIMIT) ? WORDS : bfz_pkg::SCAN_LIMIT;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
    localparam logic [bfz_pkg::BIT_IX_W-1:0] LAST_SCAN = bfz_pkg::BIT_IX_W'(SCAN_WORDS - 1);

    bfz_pkg::state_e                     state_reg, state_next;
    logic [bfz_pkg::ACT_W-1:0]           action_reg, action_next;
    logic [bfz_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [AW-1:0]                       ptr_reg, ptr_next;
    logic [bfz_pkg::BIT_IX_W-1:0]        scan_reg, scan_next;
    logic                                fill_val_reg, fill_val_next;

    logic                                in_map;
    logic [bfz_pkg::BIT_IX_W-1:0]        bit_ix;
    logic [bfz_pkg::WORD_W-1:0]          bit_mask;
    logic [bfz_pkg::WORD_W-1:0]          free_bits;
    logic [bfz_pkg::BIT_IX_W-1:0]        first_free;

    // Lowest set bit of a word
    function automatic logic [bfz_pkg::BIT_IX_W-1:0] lowest_one(
        input logic [bfz_pkg::WORD_W-1:0] v
    );
        logic [bfz_pkg::BIT_IX_W-1:0] ix;
        ix = '0;
        for (int i = bfz_pkg::WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                ix = bfz_pkg::BIT_IX_W'(i);
            end
        end
        return ix;
    endfunction

    // Decode of the held position
    assign bit_ix     = pos_reg[bfz_pkg::BIT_IX_W-1:0];
    assign in_map     = int'(pos_reg[bfz_pkg::POS_W-1:bfz_pkg::BIT_IX_W]) < WORDS;
    assign bit_mask   = bfz_pkg::WORD_W'(1) << bit_ix;
    assign free_bits  = ~rd_data;
    assign first_free = lowest_one(free_bits);

    // State and item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfz_pkg::ST_CLEAR;
            ptr_reg   <= '0;
            scan_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        pos_reg      <= pos_next;
        fill_val_reg <= fill_val_next;
    end

    // Next state, memory control and result
    always_comb begin
        state_next    = state_reg;
        action_next   = action_reg;
        pos_next      = pos_reg;
        ptr_next      = ptr_reg;
        scan_next     = scan_reg;
        fill_val_next = fill_val_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        res_data      = '0;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = AW'(pos_reg[bfz_pkg::POS_W-1:bfz_pkg::BIT_IX_W]);

        case (state_reg)
            // zero the map after reset, one word a cycle
            bfz_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_reg == LAST_WORD) begin
                    ptr_next   = '0;
                    state_next = bfz_pkg::ST_IDLE;
                end
            end

            // take a beat and start its first read (none for fills)
            bfz_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    action_next = s_data.action;
                    pos_next    = s_data.bit_position;
                    rd_en       = 1'b1;
                    rd_addr     = AW'(s_data.bit_position[bfz_pkg::POS_W-1:bfz_pkg::BIT_IX_W]);
                    case (s_data.action)
                        bfz_pkg::ACT_FIND: begin
                            rd_addr    = '0;
                            scan_next  = '0;
                            state_next = bfz_pkg::ST_SCAN;
                        end
                        bfz_pkg::ACT_FILL0, bfz_pkg::ACT_FILL1: begin
                            rd_en         = 1'b0;
                            ptr_next      = '0;
                            fill_val_next = (s_data.action == bfz_pkg::ACT_FILL1);
                            state_next    = bfz_pkg::ST_FILL;
                        end
                        default: begin
                            state_next = bfz_pkg::ST_RMW;
                        end
                    endcase
                end
            end

            // get, set, clear (and unused codes) on the word just read
            bfz_pkg::ST_RMW: begin
                res_valid = 1'b1;
                wr_addr   = AW'(pos_reg[bfz_pkg::POS_W-1:bfz_pkg::BIT_IX_W]);
                if (action_reg == bfz_pkg::ACT_GET) begin
                    res_data.bit_value = in_map ? rd_data[bit_ix] : 1'b0;
                end
                if (action_reg == bfz_pkg::ACT_SET) begin
                    wr_data = rd_data | bit_mask;
                end else begin
                    wr_data = rd_data & ~bit_mask;
                end
                wr_en = res_ready && in_map
                        && (action_reg inside {bfz_pkg::ACT_SET, bfz_pkg::ACT_CLEAR});
                if (res_ready) begin
                    state_next = bfz_pkg::ST_IDLE;
                end
            end

            // walk words from zero until one has a clear bit or the last is reached
            bfz_pkg::ST_SCAN: begin
                if ((|free_bits) || (scan_reg == LAST_SCAN)) begin
                    res_valid      = 1'b1;
                    res_data.found = |free_bits;
                    if (|free_bits) begin
                        res_data.free_index = {scan_reg, first_free};
                    end
                    if (res_ready) begin
                        state_next = bfz_pkg::ST_IDLE;
                    end
                end else begin
                    scan_next = scan_reg + bfz_pkg::BIT_IX_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = AW'(scan_reg + bfz_pkg::BIT_IX_W'(1));
                end
            end

            // write every word with all zeros or all ones
            bfz_pkg::ST_FILL: begin
                wr_data = {bfz_pkg::WORD_W{fill_val_reg}};
                if (ptr_reg == LAST_WORD) begin
                    res_valid = 1'b1;
                    wr_en     = res_ready;
                    if (res_ready) begin
                        ptr_next   = '0;
                        state_next = bfz_pkg::ST_IDLE;
                    end
                end else begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            default: begin
                state_next = bfz_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/bitmap_find_first_zero.sv
// Bitmap allocator with lowest-free-bit search.
// Input channel s_*: one beat = action (get, set, clear, find first zero,
// fill zeros, fill ones) and a 10-bit bit position (word = pos[9:5],
// bit = pos[4:0]). Result channel m_*: one beat per input beat, with
// bit_value (get), found and free_index (find); unused fields are zero.
// Work per action, with the output register free:
//   get / set / clear / unused codes : one read of the addressed word
//   find first zero                  : 1 to min(WORDS,32) words, one
//                                      word read per cycle from the store
//   fill zeros / fill ones           : all WORDS words, one word written
//                                      per cycle
// One item is in work at a time; the next beat is taken in the cycle after the
// previous result is loaded into the output register.
// Reset (aresetn low, synchronous) empties the output register and starts
// a clearing pass over all WORDS words, during which s_ready stays low.
// When the receiver stalls, the result holds in the output register; one
// further item is taken and processed, then waits until the register frees.
// Depends on bfz_pkg, bfz_ctrl, bfz_mem.
`timescale 1ns / 1ps

module bitmap_find_first_zero #(
    parameter int WORDS = bfz_pkg::WORDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfz_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfz_pkg::out_beat_t   m_data
);

    localparam int AW = bfz_pkg::addr_width(WORDS);

    logic                        res_valid;
    logic                        res_ready;
    bfz_pkg::out_beat_t          res_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [bfz_pkg::WORD_W-1:0]  wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [bfz_pkg::WORD_W-1:0]  rd_data;

    logic                        m_valid_reg;
    bfz_pkg::out_beat_t          m_data_reg;

    bfz_ctrl #(
        .WORDS (WORDS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bfz_mem #(
        .WORDS (WORDS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: free when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/bfz_checker.sv
// Port checker for the bitmap find-first-zero block, bound to the top level.
// Depends on bfz_pkg and bitmap_find_first_zero_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_find_first_zero_macros.svh"

module bfz_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input bfz_pkg::out_beat_t   m_data
);

    // stalled result beat holds
    `BFZ_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // reset empties the output and blocks input for the clearing pass
    `BFZ_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid && !s_ready)

    // no index without a hit
    `BFZ_ASSERT(a_index_zero, aclk, aresetn, m_valid && !m_data.found |-> m_data.free_index == 0)

    // a beat carries either a get value or a scan hit, never both
    `BFZ_ASSERT(a_one_kind, aclk, aresetn, m_valid |-> !(m_data.bit_value && m_data.found))

endmodule

bind bitmap_find_first_zero bfz_checker u_bfz_checker (.*);

>>> test/tb.sv
// Self-checking testbench for bitmap_find_first_zero: drives get, set, clear,
// find-first-zero and fill beats and checks each result against a bitmap predictor.
// Depends on bfz_pkg and the bitmap_find_first_zero RTL.
`timescale 1ns / 1ps

module tb;
    import bfz_pkg::*;

    localparam int MAP_WORDS    = WORDS_DEF;
    localparam int DRAIN_CYCLES = MAP_WORDS + 8;   // longest fill plus margin
    localparam int MAX_REPORTS  = 100;

    // Action codes with no function: the block must answer with an all-zero result
    localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_beat_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_beat_t m_data;

    // Predictor state and the results still owed by the block
    logic [WORD_W-1:0] map_model [MAP_WORDS];
    out_beat_t         pending_results [$];
    out_beat_t         last_result;
    int                fail_count = 0;
    int                beats_sent = 0;
    int                burst_left = 0;

    bitmap_find_first_zero #(
        .WORDS(MAP_WORDS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Apply one beat to the bitmap copy and return the result it should give
    function automatic out_beat_t map_apply(input in_beat_t beat);
        out_beat_t          res;
        logic [4:0]         word_ix;
        logic [BIT_IX_W-1:0] bit_ix;
        int                 w;
        int                 b;
        res     = '0;
        word_ix = beat.bit_position[POS_W-1:BIT_IX_W];
        bit_ix  = beat.bit_position[BIT_IX_W-1:0];
        case (beat.action)
            ACT_GET:   res.bit_value = map_model[word_ix][bit_ix];
            ACT_SET:   map_model[word_ix][bit_ix] = 1'b1;
            ACT_CLEAR: map_model[word_ix][bit_ix] = 1'b0;
            ACT_FIND: begin
                // lowest word first, lowest bit first within the word
                for (w = 0; w < MAP_WORDS && !res.found; w++) begin
                    for (b = 0; b < WORD_W && !res.found; b++) begin
                        if (!map_model[w][b]) begin
                            res.found      = 1'b1;
                            res.free_index = POS_W'(w * WORD_W + b);
                        end
                    end
                end
            end
            ACT_FILL0: begin
                for (w = 0; w < MAP_WORDS; w++) map_model[w] = '0;
            end
            ACT_FILL1: begin
                for (w = 0; w < MAP_WORDS; w++) map_model[w] = '1;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Send one beat, record its expected result, then maybe idle between bursts
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos);
        in_beat_t beat;
        int       gap;
        beat.action       = act;
        beat.bit_position = pos;
        s_data  <= beat;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_result = map_apply(beat);
        pending_results.push_back(last_result);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 4);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Hold the input side quiet until the block has answered everything
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Corner cases: map ends, scans over empty and full maps, spare codes
    task automatic test_directed();
        send_beat(ACT_GET, 10'd0);
        send_beat(ACT_FIND, 10'd1023);
        send_beat(ACT_SET, 10'd0);
        send_beat(ACT_SET, 10'd1023);
        send_beat(ACT_GET, 10'd0);
        send_beat(ACT_GET, 10'd1023);
        send_beat(ACT_FIND, 10'd0);
        send_beat(ACT_SET, 10'd31);
        send_beat(ACT_SET, 10'd32);
        send_beat(ACT_CLEAR, 10'd0);
        send_beat(ACT_FIND, 10'h155);
        send_beat(ACT_FILL1, 10'd1023);
        send_beat(ACT_FIND, 10'd0);            // full map: nothing free
        send_beat(ACT_GET, 10'h2aa);
        send_beat(ACT_CLEAR, 10'd1023);
        send_beat(ACT_FIND, 10'h2aa);          // only the top bit is free
        send_beat(ACT_CLEAR, 10'h155);
        send_beat(ACT_FIND, 10'd0);
        send_beat(ACT_SPARE6, 10'd1023);
        send_beat(ACT_SPARE7, 10'd0);
        send_beat(ACT_FILL0, 10'h155);
        send_beat(ACT_GET, 10'd1023);
        send_beat(ACT_FIND, 10'd1023);
    endtask

    // Allocator-style use: find a free bit, claim it, free bits, refill the map
    task automatic test_allocator_traffic(input int n_beats);
        int start;
        int scenario;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            scenario = $urandom_range(0, 9);
            if (scenario == 0) begin
                // nearly full map so the scan runs deep
                send_beat(ACT_FILL1, 10'($urandom_range(0, 1023)));
                repeat ($urandom_range(0, 4)) send_beat(ACT_CLEAR, 10'($urandom_range(0, 1023)));
                send_beat(ACT_FIND, 10'($urandom_range(0, 1023)));
            end else if (scenario == 1) begin
                send_beat(ACT_FILL0, 10'($urandom_range(0, 1023)));
            end else if (scenario <= 6) begin
                repeat ($urandom_range(1, 8)) begin
                    send_beat(ACT_FIND, 10'($urandom_range(0, 1023)));
                    if (last_result.found) send_beat(ACT_SET, last_result.free_index);
                end
            end else if (scenario <= 8) begin
                send_beat(ACT_CLEAR, 10'($urandom_range(0, 1023)));
                send_beat(ACT_GET, 10'($urandom_range(0, 1023)));
            end else begin
                send_beat($urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7,
                          10'($urandom_range(0, 1023)));
            end
        end
    endtask

    // Unstructured traffic over every action code and position
    task automatic test_random_mix(input int n_beats);
        int                 start;
        int                 pick;
        logic [ACT_W-1:0]   act;
        logic [POS_W-1:0]   pos;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      act = ACT_SET;
            else if (pick < 50) act = ACT_CLEAR;
            else if (pick < 70) act = ACT_GET;
            else if (pick < 88) act = ACT_FIND;
            else if (pick < 91) act = ACT_FILL0;
            else if (pick < 94) act = ACT_FILL1;
            else if (pick < 97) act = ACT_SPARE6;
            else                act = ACT_SPARE7;
            // favor the low words so scans see a mixed prefix
            pos = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 127));
            send_beat(act, pos);
        end
    endtask

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t ns: result beat with none expected, expected none, actual %h",
                             $time, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.bit_value !== want.bit_value)
                    report_mismatch("bit_value", want.bit_value, m_data.bit_value);
                if (m_data.found !== want.found)
                    report_mismatch("found", want.found, m_data.found);
                if (m_data.free_index !== want.free_index)
                    report_mismatch("free_index", want.free_index, m_data.free_index);
            end
        end
    end

    // Receiver back-pressure: switches between randomly chosen modes
    initial begin
        int mode;
        int hold;
        m_ready <= 1'b0;
        mode = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(30, 150);
            end
            hold--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= (hold % 4 == 0);
                default: m_ready <= (hold % 24 >= 18);   // long stalls
            endcase
        end
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        for (int w = 0; w < MAP_WORDS; w++) map_model[w] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_allocator_traffic(900);
        // sender holds off until every outstanding result is back
        wait_results_drained();
        test_random_mix(1000);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
